FILE: hdl/crsr_pkg.sv
// Shared types and constants for the clipped rectangle span raster.
package crsr_pkg;

    // Signed width used for all row and column arithmetic.
    localparam int CW = 19;
    localparam int COL_W = 14;
    localparam int LEN_W = 14;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_STRIDE   = 2'd2;

    // Command opcodes.
    localparam logic [2:0] OP_FILL    = 3'd0;
    localparam logic [2:0] OP_OUTLINE = 3'd1;
    localparam logic [2:0] OP_GRAD    = 3'd2;
    localparam logic [2:0] OP_ROUND   = 3'd3;
    localparam logic [2:0] OP_STEP    = 3'd4;

    // Shape kinds as stored.
    localparam logic [1:0] KIND_FILL    = 2'd0;
    localparam logic [1:0] KIND_OUTLINE = 2'd1;
    localparam logic [1:0] KIND_GRAD    = 2'd2;
    localparam logic [1:0] KIND_ROUND   = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic [13:0]        corner_radius;
        logic [31:0]        color_first;
        logic [31:0]        color_second;
    } in_item_t;

    typedef struct packed {
        logic [24:0] span_start;
        logic [12:0] span_length;
        logic [31:0] span_color;
        logic        last_span;
    } out_item_t;

    // Visible spans of one shape row.
    typedef struct packed {
        logic [1:0]       cnt;
        logic [COL_W-1:0] col0;
        logic [LEN_W-1:0] len0;
        logic [COL_W-1:0] col1;
        logic [LEN_W-1:0] len1;
    } row_spans_t;

endpackage

FILE: hdl/clipped_rect_span_raster.sv
// Top level of the clipped rectangle span raster.
//
// A command item (fill, outline, gradient, rounded fill) latches a shape and
// searches for its first visible row; it gives no result unless the shape is
// empty or wholly off screen, in which case one span of length 0 marked last
// is returned. Each step item then returns the next visible row as one or two
// spans, the last span of the last visible row marked last. A step while idle gives nothing.
// Items are taken on s_valid & s_ready; results leave on m_valid & m_ready.
// The block takes one item at a time and s_ready stays low until all results
// of the item have been taken, so a stalled receiver holds the block.
// Inside a rounded corner band each row examined also has its inset found
// with a 16-step square root. A step adds the gradient dividers, one per
// channel for a gradient shape, the row offset multiply and the output of
// each span, which waits while the receiver stalls; the row search also looks
// one row ahead, and the row found ahead is examined again by the next step.
// Synchronous active-low reset returns the block to idle with the default
// screen of 1280 x 720 and a stride of 1280.
module clipped_rect_span_raster
    import crsr_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = 4096,
    parameter int MAX_STRIDE     = 8192
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [13:0] cfg_wdata
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_ROW   = 14'b00000000000010,
        ST_SQ_A  = 14'b00000000000100,
        ST_SQ_B  = 14'b00000000001000,
        ST_SQ_C  = 14'b00000000010000,
        ST_SQRT  = 14'b00000000100000,
        ST_CHECK = 14'b00000001000000,
        ST_GMUL  = 14'b00000010000000,
        ST_GDIV0 = 14'b00000100000000,
        ST_GDIV  = 14'b00001000000000,
        ST_GFIN  = 14'b00010000000000,
        ST_BASE  = 14'b00100000000000,
        ST_BASE2 = 14'b01000000000000,
        ST_EMIT  = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        MODE_CMD,
        MODE_FIRST,
        MODE_NEXT
    } mode_t;

    state_t state_reg;
    mode_t  mode_reg;

    logic [12:0] sw_reg, sh_reg;
    logic [13:0] stride_reg;

    logic               busy_reg;
    logic [1:0]         kind_reg;
    logic signed [15:0] left_reg, top_reg, w_reg, h_reg;
    logic [15:0]        row_cnt_reg;
    logic [13:0]        radius_reg;
    logic [31:0]        cola_reg, colb_reg;

    logic signed [CW-1:0] cur_dy_reg;
    logic [15:0]          dy_cur_reg;
    logic [14:0]          band_reg;
    logic [13:0]          inset_reg;
    logic [31:0]          rsq_reg, v_reg, res_reg, bit_reg;
    logic [4:0]           iter_reg;
    logic [1:0]           chan_reg;
    logic [15:0]          rem_reg;
    logic [22:0]          quo_reg;
    logic                 neg_reg;
    logic [23:0]          grad_reg;
    logic [24:0]          base_reg;
    logic                 last_reg;
    logic                 emit_idx_reg;
    row_spans_t           spans_reg;

    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_reg;

    logic      m_valid_reg;
    out_item_t m_item_reg;

    // Effective screen and stride after saturation.
    logic signed [CW-1:0] eff_w, eff_h, x_s, w_s, h_s, top_s, dy_s, hi, neg_top;
    logic [15:0]          eff_stride;
    always_comb begin
        eff_w = (32'(sw_reg) > MAX_ROW_PIXELS) ? CW'(MAX_ROW_PIXELS) : CW'(sw_reg);
        eff_h = (32'(sh_reg) > MAX_ROW_PIXELS) ? CW'(MAX_ROW_PIXELS) : CW'(sh_reg);
        eff_stride = (32'(stride_reg) > MAX_STRIDE) ? 16'(MAX_STRIDE) : 16'(stride_reg);
        x_s   = CW'(left_reg);
        w_s   = CW'(w_reg);
        h_s   = CW'(h_reg);
        top_s = CW'(top_reg);
        dy_s  = cur_dy_reg;
        neg_top = -top_s;
        hi = ((eff_h - top_s) < h_s) ? eff_h - top_s : h_s;
    end

    // Corner band test for the row under examination.
    logic signed [CW-1:0] r_s, bot_dist;
    logic                 in_top, in_bot, in_band;
    logic [14:0]          band_row;
    always_comb begin
        r_s      = CW'(signed'({1'b0, radius_reg}));
        bot_dist = h_s - CW'(1) - dy_s;
        in_top   = dy_s < r_s;
        in_bot   = bot_dist < r_s;
        in_band  = (kind_reg == KIND_ROUND) && (in_top || in_bot);
        band_row = in_top ? dy_s[14:0] : bot_dist[14:0];
    end

    // Row span evaluation.
    row_spans_t cur_spans;
    crsr_clip u_clip (
        .kind  (kind_reg),
        .x     (x_s),
        .w     (w_s),
        .h     (h_s),
        .dy    (dy_s),
        .inset (CW'(signed'({1'b0, inset_reg}))),
        .scr_w (eff_w),
        .spans (cur_spans)
    );

    // Shared multiplier operand selection.
    logic [14:0] cy;
    logic [7:0]  ch_t, ch_b;
    logic signed [8:0] ch_diff;
    always_comb begin
        cy      = 15'(radius_reg) - 15'd1 - band_reg;
        ch_t    = cola_reg[8*chan_reg +: 8];
        ch_b    = colb_reg[8*chan_reg +: 8];
        ch_diff = signed'({1'b0, ch_b}) - signed'({1'b0, ch_t});
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            ST_SQ_A: begin
                mul_a = signed'({4'b0, radius_reg});
                mul_b = signed'({4'b0, radius_reg});
            end
            ST_SQ_B: begin
                mul_a = signed'({3'b0, cy});
                mul_b = signed'({3'b0, cy});
            end
            ST_GMUL: begin
                mul_a = 18'(ch_diff);
                mul_b = signed'({2'b0, dy_cur_reg});
            end
            ST_BASE: begin
                mul_a = 18'(top_s + CW'(signed'({1'b0, dy_cur_reg})));
                mul_b = signed'({2'b0, eff_stride});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root step.
    logic [31:0] sq_sum, sq_v_next, sq_res_next;
    logic [13:0] sq_inset;
    always_comb begin
        sq_sum = res_reg + bit_reg;
        if (v_reg >= sq_sum) begin
            sq_v_next   = v_reg - sq_sum;
            sq_res_next = (res_reg >> 1) + bit_reg;
        end else begin
            sq_v_next   = v_reg;
            sq_res_next = res_reg >> 1;
        end
        if (sq_res_next >= 32'(radius_reg) - 32'd1) begin
            sq_inset = '0;
        end else begin
            sq_inset = radius_reg - 14'd1 - sq_res_next[13:0];
        end
    end

    // Divider step and gradient channel result.
    logic [16:0] div_shift;
    logic [23:0] ch_sum;
    always_comb begin
        div_shift = {rem_reg, quo_reg[22]};
        ch_sum = neg_reg ? 24'(ch_t) - 24'(quo_reg) : 24'(ch_t) + 24'(quo_reg);
    end

    // Command decode and radius clamp.
    logic        s_fire, cmd_empty;
    logic [13:0] r_clamp;
    logic [14:0] half_w, half_h;
    always_comb begin
        s_fire    = s_valid && s_ready;
        cmd_empty = (s_item.box_width <= 0) || (s_item.box_height <= 0);
        half_w    = s_item.box_width[15:1];
        half_h    = s_item.box_height[15:1];
        r_clamp   = s_item.corner_radius;
        if (15'(r_clamp) > half_w) r_clamp = half_w[13:0];
        if (15'(r_clamp) > half_h) r_clamp = half_h[13:0];
    end

    // Outcome of the row search.
    logic search_done, search_found;
    always_comb begin
        search_done  = ((state_reg == ST_ROW) && (dy_s >= neg_top) && (dy_s >= hi)) ||
                       ((state_reg == ST_CHECK) && (cur_spans.cnt != 2'd0));
        search_found = (state_reg == ST_CHECK);
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg     <= 13'd1280;
            sh_reg     <= 13'd720;
            stride_reg <= 14'd1280;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  sw_reg     <= cfg_wdata[12:0];
                CFG_SCREEN_HEIGHT: sh_reg     <= cfg_wdata[12:0];
                CFG_LINE_STRIDE:   stride_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Shared multiplier.
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_CMD;
            busy_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            kind_reg     <= '0;
            row_cnt_reg  <= '0;
            radius_reg   <= '0;
            emit_idx_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_item.opcode <= OP_ROUND)) begin
                        kind_reg    <= s_item.opcode[1:0];
                        left_reg    <= s_item.x_pos;
                        top_reg     <= s_item.y_pos;
                        w_reg       <= s_item.box_width;
                        h_reg       <= s_item.box_height;
                        cola_reg    <= s_item.color_first;
                        colb_reg    <= s_item.color_second;
                        busy_reg    <= 1'b0;
                        row_cnt_reg <= '0;
                        radius_reg  <= '0;
                        if (cmd_empty) begin
                            m_item_reg  <= '{span_start: '0, span_length: '0,
                                             span_color: '0, last_span: 1'b1};
                            m_valid_reg <= 1'b1;
                        end else begin
                            if (s_item.opcode == OP_ROUND) radius_reg <= r_clamp;
                            cur_dy_reg <= '0;
                            mode_reg   <= MODE_CMD;
                            state_reg  <= ST_ROW;
                        end
                    end else if (s_fire && (s_item.opcode == OP_STEP) && busy_reg) begin
                        cur_dy_reg <= CW'(signed'({1'b0, row_cnt_reg}));
                        mode_reg   <= MODE_FIRST;
                        state_reg  <= ST_ROW;
                    end
                end
                ST_ROW: begin
                    if (dy_s < neg_top) begin
                        cur_dy_reg <= neg_top;
                    end else if (dy_s < hi) begin
                        band_reg  <= band_row;
                        inset_reg <= '0;
                        state_reg <= in_band ? ST_SQ_A : ST_CHECK;
                    end
                end
                ST_SQ_A: state_reg <= ST_SQ_B;
                ST_SQ_B: begin
                    rsq_reg   <= mul_reg[31:0];
                    state_reg <= ST_SQ_C;
                end
                ST_SQ_C: begin
                    v_reg     <= rsq_reg - mul_reg[31:0];
                    res_reg   <= '0;
                    bit_reg   <= 32'h4000_0000;
                    iter_reg  <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    v_reg    <= sq_v_next;
                    res_reg  <= sq_res_next;
                    bit_reg  <= bit_reg >> 2;
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'd15) begin
                        inset_reg <= sq_inset;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (cur_spans.cnt == 2'd0) begin
                        cur_dy_reg <= cur_dy_reg + CW'(1);
                        state_reg  <= ST_ROW;
                    end
                end
                ST_GMUL: state_reg <= ST_GDIV0;
                ST_GDIV0: begin
                    neg_reg   <= mul_reg[35];
                    quo_reg   <= mul_reg[35] ? 23'(-mul_reg) : mul_reg[22:0];
                    rem_reg   <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_GDIV;
                end
                ST_GDIV: begin
                    if (div_shift >= 17'(h_reg)) begin
                        rem_reg <= 16'(div_shift - 17'(h_reg));
                        quo_reg <= {quo_reg[21:0], 1'b1};
                    end else begin
                        rem_reg <= div_shift[15:0];
                        quo_reg <= {quo_reg[21:0], 1'b0};
                    end
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'd22) state_reg <= ST_GFIN;
                end
                ST_GFIN: begin
                    grad_reg[8*chan_reg +: 8] <= ch_sum[7:0];
                    if (chan_reg == 2'd0) begin
                        state_reg <= ST_BASE;
                    end else begin
                        chan_reg  <= chan_reg - 2'd1;
                        state_reg <= ST_GMUL;
                    end
                end
                ST_BASE: state_reg <= ST_BASE2;
                ST_BASE2: begin
                    base_reg   <= mul_reg[24:0];
                    cur_dy_reg <= CW'(signed'({1'b0, dy_cur_reg})) + CW'(1);
                    mode_reg   <= MODE_NEXT;
                    state_reg  <= ST_ROW;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_item_reg.span_color <= (kind_reg == KIND_GRAD) ?
                                                 {8'h00, grad_reg} : cola_reg;
                        if (!emit_idx_reg) begin
                            m_item_reg.span_start  <= base_reg + 25'(spans_reg.col0);
                            m_item_reg.span_length <= spans_reg.len0[12:0];
                            m_item_reg.last_span   <= last_reg && (spans_reg.cnt == 2'd1);
                        end else begin
                            m_item_reg.span_start  <= base_reg + 25'(spans_reg.col1);
                            m_item_reg.span_length <= spans_reg.len1[12:0];
                            m_item_reg.last_span   <= last_reg;
                        end
                        if (emit_idx_reg || (spans_reg.cnt == 2'd1)) begin
                            emit_idx_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            emit_idx_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // Resolution of a finished row search.
            if (search_done) begin
                case (mode_reg)
                    MODE_CMD: begin
                        if (search_found) begin
                            busy_reg    <= 1'b1;
                            row_cnt_reg <= cur_dy_reg[15:0];
                        end else begin
                            m_item_reg  <= '{span_start: '0, span_length: '0,
                                             span_color: '0, last_span: 1'b1};
                            m_valid_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                    MODE_FIRST: begin
                        if (search_found) begin
                            dy_cur_reg <= cur_dy_reg[15:0];
                            spans_reg  <= cur_spans;
                            chan_reg   <= 2'd2;
                            state_reg  <= (kind_reg == KIND_GRAD) ? ST_GMUL : ST_BASE;
                        end else begin
                            busy_reg    <= 1'b0;
                            m_item_reg  <= '{span_start: '0, span_length: '0,
                                             span_color: '0, last_span: 1'b1};
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    default: begin
                        if (search_found) begin
                            row_cnt_reg <= cur_dy_reg[15:0];
                            last_reg    <= 1'b0;
                        end else begin
                            busy_reg <= 1'b0;
                            last_reg <= 1'b1;
                        end
                        emit_idx_reg <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The block only takes an item while idle with no result pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE) && !m_valid_reg)
        else $error("s_ready raised outside idle");

    // An empty span always closes its command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.span_length == '0)) |-> m_item.last_span)
        else $error("empty span not marked last");

    // Emission only runs with one or two latched spans.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ((spans_reg.cnt == 2'd1) || (spans_reg.cnt == 2'd2)))
        else $error("bad span count in emission");

    // The square root never runs past its sixteen steps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (iter_reg <= 5'd15))
        else $error("square root step count overrun");
`endif

endmodule

FILE: hdl/crsr_clip.sv
// Row span evaluation: clips the spans of one shape row to the screen.
module crsr_clip
    import crsr_pkg::*;
(
    input  logic [1:0]         kind,
    input  logic signed [CW-1:0] x,
    input  logic signed [CW-1:0] w,
    input  logic signed [CW-1:0] h,
    input  logic signed [CW-1:0] dy,
    input  logic signed [CW-1:0] inset,
    input  logic signed [CW-1:0] scr_w,
    output row_spans_t         spans
);

    logic                 side_row;
    logic                 lv, rv;
    logic signed [CW-1:0] xr, a, b, ac, bc, len;

    // Outline middle rows of width over 2 are up to two one-pixel edge spans; others are at most one clipped span.
    always_comb begin
        side_row = (kind == KIND_OUTLINE) && (dy != '0) && (dy != h - CW'(1)) && (w > CW'(2));
        xr = x + w - CW'(1);
        lv = (x >= 0) && (x < scr_w);
        rv = (xr >= 0) && (xr < scr_w);
        a  = x + inset;
        b  = x + w - inset;
        ac = (a < 0) ? '0 : a;
        bc = (b > scr_w) ? scr_w : b;
        len = (bc > ac) ? bc - ac : '0;
        spans = '0;
        if (side_row) begin
            if (lv) begin
                spans.col0 = x[COL_W-1:0];
                spans.len0 = LEN_W'(1);
                if (rv) begin
                    spans.col1 = xr[COL_W-1:0];
                    spans.len1 = LEN_W'(1);
                    spans.cnt  = 2'd2;
                end else begin
                    spans.cnt = 2'd1;
                end
            end else if (rv) begin
                spans.col0 = xr[COL_W-1:0];
                spans.len0 = LEN_W'(1);
                spans.cnt  = 2'd1;
            end
        end else if (len != '0) begin
            spans.col0 = ac[COL_W-1:0];
            spans.len0 = len[LEN_W-1:0];
            spans.cnt  = 2'd1;
        end
    end

endmodule

FILE: bench/span_raster_checker.sv
// Watches the span raster channels, predicts the spans and compares them.
module span_raster_checker
    import crsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_wdata,
    output int          mismatches,
    output int          spans_pending
);

    // Screen setup as the block sees it.
    int unsigned scr_w, scr_h, stride;

    // Shape being rastered.
    logic        busy;
    logic [1:0]  kind;
    int          left, top, wid, hgt, radius;
    int          row_ptr;
    logic [31:0] col_top, col_bot;

    // Spans of the row last examined.
    int span_col0, span_col1, span_len0, span_len1;

    out_item_t span_q[$];

    assign spans_pending = span_q.size();

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned res;
        int unsigned bits;
        res = 0;
        bits = 32'h4000_0000;
        while (bits > v) bits = bits >> 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // Inset of a corner band row: first dx inside the circle.
    function automatic int corner_inset(int band_row);
        int cy;
        int unsigned s;
        cy = radius - 1 - band_row;
        s = int_sqrt($unsigned(radius * radius - cy * cy));
        if (int'(s) >= radius - 1) return 0;
        return radius - 1 - int'(s);
    endfunction

    function automatic int clip_span(int a, int b, output int col);
        int w;
        w = (scr_w > 4096) ? 4096 : int'(scr_w);
        if (a < 0) a = 0;
        if (b > w) b = w;
        col = a;
        return (b > a) ? b - a : 0;
    endfunction

    // Visible spans of shape row dy; leaves them in span_col and span_len.
    function automatic int spans_of_row(int dy);
        int a, b, ins, cnt, c, n;
        a = left;
        b = left + wid;
        if (kind == KIND_OUTLINE && dy != 0 && dy != hgt - 1 && wid > 2) begin
            cnt = 0;
            n = clip_span(left, left + 1, c);
            if (n > 0) begin
                span_col0 = c;
                span_len0 = n;
                cnt = 1;
            end
            n = clip_span(left + wid - 1, left + wid, c);
            if (n > 0) begin
                if (cnt == 0) begin
                    span_col0 = c;
                    span_len0 = n;
                end else begin
                    span_col1 = c;
                    span_len1 = n;
                end
                cnt++;
            end
            return cnt;
        end
        if (kind == KIND_ROUND) begin
            ins = 0;
            if (dy < radius) ins = corner_inset(dy);
            else if (hgt - 1 - dy < radius) ins = corner_inset(hgt - 1 - dy);
            a = left + ins;
            b = left + wid - ins;
        end
        span_len0 = clip_span(a, b, span_col0);
        return (span_len0 > 0) ? 1 : 0;
    endfunction

    // First row at or after d with something visible, or -1.
    function automatic int next_visible_row(int d);
        int lo, hi, dy;
        lo = -top;
        hi = ((scr_h > 4096) ? 4096 : int'(scr_h)) - top;
        if (lo < d) lo = d;
        if (hi > hgt) hi = hgt;
        for (dy = lo; dy < hi; dy++)
            if (spans_of_row(dy) > 0) return dy;
        return -1;
    endfunction

    function automatic logic [7:0] mix_channel(int sh, int dy);
        int t, bt;
        t = int'((col_top >> sh) & 32'hFF);
        bt = int'((col_bot >> sh) & 32'hFF);
        return 8'(t + ((bt - t) * dy) / hgt);
    endfunction

    function automatic void push_span(int unsigned start, int len, logic [31:0] c,
                                      logic fin);
        out_item_t s;
        s.span_start = start[24:0];
        s.span_length = 13'(len);
        s.span_color = c;
        s.last_span = fin;
        span_q.push_back(s);
    endfunction

    // Expected spans of one accepted item.
    function automatic void predict_item(in_item_t it);
        int dy, nx, cnt, k, r;
        int cols[2], lens[2];
        logic [31:0] colr;
        int unsigned st, eff_stride;
        if (it.opcode <= OP_ROUND) begin
            kind = it.opcode[1:0];
            left = int'(it.x_pos);
            top = int'(it.y_pos);
            wid = int'(it.box_width);
            hgt = int'(it.box_height);
            col_top = it.color_first;
            col_bot = it.color_second;
            radius = 0;
            busy = 1'b0;
            row_ptr = 0;
            if (wid <= 0 || hgt <= 0) begin
                push_span(0, 0, 32'd0, 1'b1);
                return;
            end
            if (it.opcode == OP_ROUND) begin
                r = int'(it.corner_radius);
                if (r > wid / 2) r = wid / 2;
                if (r > hgt / 2) r = hgt / 2;
                radius = r;
            end
            dy = next_visible_row(0);
            if (dy < 0) begin
                push_span(0, 0, 32'd0, 1'b1);
                return;
            end
            row_ptr = dy;
            busy = 1'b1;
            return;
        end
        if (it.opcode != OP_STEP || !busy) return;
        dy = next_visible_row(row_ptr & 32'hFFFF);
        if (dy < 0) begin
            busy = 1'b0;
            push_span(0, 0, 32'd0, 1'b1);
            return;
        end
        cnt = spans_of_row(dy);
        cols[0] = span_col0;
        cols[1] = span_col1;
        lens[0] = span_len0;
        lens[1] = span_len1;
        if (kind == KIND_GRAD)
            colr = {8'h00, mix_channel(16, dy), mix_channel(8, dy), mix_channel(0, dy)};
        else
            colr = col_top;
        nx = next_visible_row(dy + 1);
        if (nx < 0) busy = 1'b0;
        else row_ptr = nx;
        eff_stride = (stride > 8192) ? 8192 : stride;
        for (k = 0; k < cnt; k++) begin
            st = $unsigned(top + dy) * eff_stride + $unsigned(cols[k]);
            push_span(st, lens[k], colr, (nx < 0) && (k == cnt - 1));
        end
    endfunction

    // Track configuration, predict on accepted items, compare accepted spans.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            scr_w = 1280;
            scr_h = 720;
            stride = 1280;
            busy = 1'b0;
            kind = KIND_FILL;
            left = 0;
            top = 0;
            wid = 0;
            hgt = 0;
            radius = 0;
            row_ptr = 0;
            col_top = '0;
            col_bot = '0;
            span_q.delete();
            mismatches <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH: scr_w = cfg_wdata & 14'h1FFF;
                    CFG_SCREEN_HEIGHT: scr_h = cfg_wdata & 14'h1FFF;
                    CFG_LINE_STRIDE: stride = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (span_q.size() == 0) begin
                    $error("span with no expectation: start %0h", m_item.span_start);
                    mismatches <= mismatches + 1;
                end else begin
                    want = span_q.pop_front();
                    if (want !== m_item) begin
                        mismatches <= mismatches + 1;
                        if (want.span_start !== m_item.span_start)
                            $error("span_start: expected %0h got %0h",
                                   want.span_start, m_item.span_start);
                        if (want.span_length !== m_item.span_length)
                            $error("span_length: expected %0d got %0d",
                                   want.span_length, m_item.span_length);
                        if (want.span_color !== m_item.span_color)
                            $error("span_color: expected %0h got %0h",
                                   want.span_color, m_item.span_color);
                        if (want.last_span !== m_item.last_span)
                            $error("last_span: expected %0b got %0b",
                                   want.last_span, m_item.last_span);
                    end
                end
            end
            if (s_valid && s_ready) predict_item(s_item);
        end
    end

endmodule

FILE: bench/tb_clipped_rect_span_raster.sv
// Stimulus, clocking and verdict for the clipped rectangle span raster.
module tb_clipped_rect_span_raster;
    import crsr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SCREEN_WIDTH;
    logic [13:0] cfg_wdata = '0;
    int          mismatches;
    int          spans_pending;
    logic        calm = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          scr_w = 1280, scr_h = 720;

    always #2 aclk = ~aclk;

    clipped_rect_span_raster uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    span_raster_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .spans_pending(spans_pending)
    );

    // Receiver stalls: mostly short, a few long, none while calm.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                           : $urandom_range(1, 3);
        end
    end

    // Watchdog on cycles with no item moving on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 400000) begin
            $display("FAIL clipped_rect_span_raster");
            $finish;
        end
    end

    function automatic in_item_t make_item(logic [2:0] op, int x, int y, int w, int h,
                                           int r, logic [31:0] c1, logic [31:0] c2);
        in_item_t it;
        it.opcode = op;
        it.x_pos = 16'(x);
        it.y_pos = 16'(y);
        it.box_width = 16'(w);
        it.box_height = 16'(h);
        it.corner_radius = 14'(r);
        it.color_first = c1;
        it.color_second = c2;
        return it;
    endfunction

    // Offer one item after an optional gap and hold it until taken.
    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_steps(int n);
        repeat (n) send_item(make_item(OP_STEP, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom));
    endtask

    // Reprogram the screen once the block has drained and gone idle.
    task automatic set_screen(int w, int h, int st);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (spans_pending != 0 || !s_ready) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_wdata <= 14'(w);
        @(posedge aclk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_wdata <= 14'(h);
        @(posedge aclk);
        cfg_index <= CFG_LINE_STRIDE;
        cfg_wdata <= 14'(st);
        @(posedge aclk);
        cfg_we <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    // One random shape followed by a random number of row steps.
    task automatic random_shape(output int sent);
        logic [2:0] op;
        int x, y, w, h, r, n;
        op = 3'($urandom_range(0, 3));
        x = $urandom_range(0, scr_w + 80) - 40;
        y = $urandom_range(0, scr_h + 80) - 40;
        w = $urandom_range(1, 60);
        h = $urandom_range(1, 30);
        r = $urandom_range(0, 20);
        case ($urandom_range(0, 19))
            0: x = $urandom_range(0, 65535);
            1: y = $urandom_range(0, 65535);
            2: w = -int'($urandom_range(0, 32768));
            3: h = -int'($urandom_range(0, 32768));
            4: r = $urandom_range(0, 16383);
            5: w = $urandom_range(1, 32767);
            default: ;
        endcase
        n = $urandom_range(0, h + 3);
        if (n > 40) n = 40;
        send_item(make_item(op, x, y, w, h, r, $urandom, $urandom));
        send_steps(n);
        sent = n + 1;
    endtask

    initial begin
        int count, got, ph;
        int w_set[7] = '{1280, 1, 4096, 64, 4096, 1, 1000};
        int h_set[7] = '{720, 1, 4096, 48, 1, 4096, 600};
        int s_set[7] = '{1280, 1, 8192, 100, 8192, 1, 8191};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed shapes under the reset screen.
        send_steps(1);
        send_item(make_item(OP_FILL, 10, 5, 8, 3, 0, 32'hDEADBEEF, 0));
        send_steps(4);
        send_item(make_item(OP_OUTLINE, -1, 0, 3, 4, 0, 32'h00FF00FF, 0));
        send_steps(5);
        send_item(make_item(OP_OUTLINE, 1278, 718, 2, 3, 0, 32'h12345678, 0));
        send_steps(3);
        send_item(make_item(OP_GRAD, 0, 0, 4, 5, 0, 32'hFFFFFFFF, 32'h00000000));
        send_steps(6);
        send_item(make_item(OP_ROUND, 100, 100, 30, 20, 16383, 32'hA5A5A5A5, 0));
        send_steps(3);
        send_item(make_item(OP_FILL, 0, 0, 0, 5, 0, 32'h1, 0));
        send_item(make_item(OP_FILL, 0, 0, 5, -32768, 0, 32'h1, 0));
        send_item(make_item(OP_GRAD, 32767, -32768, 32767, 32767, 0, 0, 32'hFFFFFF));
        send_item(make_item(OP_FILL, -32768, 700, 32767, 30, 0, 32'h7, 0));
        send_item(make_item(3'd5, 1, 2, 3, 4, 5, 6, 7));
        send_item(make_item(3'd7, -1, -1, -1, -1, 16383, '1, '1));
        send_steps(2);

        // Random phases, one screen setting each, the extremes among them.
        count = 0;
        for (ph = 0; ph < 7; ph++) begin
            set_screen(w_set[ph], h_set[ph], s_set[ph]);
            calm = (ph == 3);
            while (count < (ph + 1) * 285) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(make_item(3'($urandom_range(4, 7)), $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom,
                                        $urandom));
                    count++;
                end else begin
                    random_shape(got);
                    count += got;
                end
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Drain, then let the block settle before the verdict.
        @(posedge aclk);
        while (spans_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && spans_pending == 0)
            $display("PASS clipped_rect_span_raster");
        else
            $display("FAIL clipped_rect_span_raster");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/crsr_pkg.sv
hdl/crsr_clip.sv
hdl/clipped_rect_span_raster.sv
bench/span_raster_checker.sv
bench/tb_clipped_rect_span_raster.sv
